### src/polygon_shape_analyzer_unit_defines.svh
// ----------------------------------------------------------------------------
// polygon shape analyzer assertion macros
// immediate-to-property wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef POLYGON_SHAPE_ANALYZER_UNIT_DEFINES_SVH
`define POLYGON_SHAPE_ANALYZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon shape analyzer check failed");
`define PSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon shape analyzer check failed");
`else
`define PSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// shared types, sizes and geometry helpers of the polygon shape analyzer
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = ADDR_BITS + 1;
    localparam int AREA_BITS    = 33;
    localparam int SUM_BITS     = 2 * COORD_BITS + 1 + CNT_BITS;

    typedef logic signed [COORD_BITS-1:0]   t_coord;
    typedef logic signed [COORD_BITS:0]     t_diff;
    typedef logic signed [2*COORD_BITS+1:0] t_prod;
    typedef logic signed [2*COORD_BITS+2:0] t_cross;
    typedef logic signed [SUM_BITS-1:0]     t_sum;
    typedef logic [ADDR_BITS-1:0]           t_addr;
    typedef logic [CNT_BITS-1:0]            t_cnt;
    typedef logic [AREA_BITS-1:0]           t_area;
    typedef logic [1:0]                     t_ocode;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    localparam t_ocode OR_ZERO = 2'd0;
    localparam t_ocode OR_POS  = 2'd1;
    localparam t_ocode OR_NEG  = 2'd2;

    // (a1 - a0) * (b1 - b0)
    function automatic t_prod dmul(t_coord a1, t_coord a0, t_coord b1, t_coord b0);
        t_diff da;
        t_diff db;
        da = t_diff'(a1) - t_diff'(a0);
        db = t_diff'(b1) - t_diff'(b0);
        return t_prod'(da) * t_prod'(db);
    endfunction

    function automatic t_ocode ocode(t_prod ab, t_prod cd);
        t_cross v;
        v = t_cross'(ab) - t_cross'(cd);
        if (v == '0) return OR_ZERO;
        return v[$bits(t_cross)-1] ? OR_NEG : OR_POS;
    endfunction

    // q lies inside the bounding box of p and r
    function automatic logic in_box(t_pt p, t_pt q, t_pt r);
        logic ok_x;
        logic ok_y;
        ok_x = (q.x <= p.x || q.x <= r.x) && (q.x >= p.x || q.x >= r.x);
        ok_y = (q.y <= p.y || q.y <= r.y) && (q.y >= p.y || q.y >= r.y);
        return ok_x && ok_y;
    endfunction

endpackage

### src/psa_if.sv
// ----------------------------------------------------------------------------
// psa channel interfaces
// vertex input channel and shape result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface psa_in_if;
    import psa_pkg::*;
    logic   valid;
    logic   ready;
    t_coord vertex_x;
    t_coord vertex_y;
    logic   last_vertex;
    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

interface psa_out_if;
    import psa_pkg::*;
    logic  valid;
    logic  ready;
    logic  well_formed;
    logic  crossed;
    logic  convex;
    logic  concave;
    logic  area_valid;
    t_area twice_area;
    logic  overflow;
    modport source (output valid, output well_formed, output crossed, output convex,
                    output concave, output area_valid, output twice_area, output overflow,
                    input ready);
    modport sink   (input valid, input well_formed, input crossed, input convex,
                    input concave, input area_valid, input twice_area, input overflow,
                    output ready);
endinterface

### src/polygon_shape_analyzer_unit.sv
// after the last vertex: a turn/area pass, then, at four vertices or more, for each
// first edge i a fetch, a latch and one tested edge pair per cycle, then a drain
// (below three vertices both passes are skipped); the pairs run through the single
// edge-pair test pipeline fed from the two read ports of the vertex store.
// vertices load at one per cycle while idle; the result sits in an output register and
// a new polygon loads while it waits. reset clears the control state, not the vertex store.
`include "polygon_shape_analyzer_unit_defines.svh"
// ----------------------------------------------------------------------------
// polygon_shape_analyzer_unit
// stores a polygon and reports well formed, crossed, convex, concave and area
// ----------------------------------------------------------------------------
module polygon_shape_analyzer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psa_in_if.sink    i_vtx,
    psa_out_if.source o_res
);
    import psa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CV     = 3'd1;
    localparam logic [2:0] S_CR_OUT = 3'd2;
    localparam logic [2:0] S_CR_LAT = 3'd3;
    localparam logic [2:0] S_CR_IN  = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    t_pt        mem [MAX_VERTICES];
    logic [2:0] r_state;
    t_cnt       r_count, n_count;
    logic       r_ovf;
    t_cnt       r_s, r_i, r_j;
    logic       r_drn;
    t_addr      addr_a, addr_b;
    t_pt        r_rd_a, r_rd_b;

    // turn / area pipeline
    logic       r_cv_v1, r_cv_pair1, r_cv_tri1;
    logic       r_cv_v2, r_cv_pair2, r_cv_tri2;
    t_pt        r_wa, r_wb;
    t_prod      r_c_t1, r_c_t2, r_c_s1, r_c_s2;
    t_sum       r_sum;
    logic       r_sign_set, r_sign_neg, r_nonconvex;
    t_ocode     cv_code;

    // edge pair pipeline
    logic       r_x_v1, r_x_v2;
    t_pt        r_p1, r_q1;
    t_pt        r_x_p1, r_x_q1, r_x_p2, r_x_q2;
    t_prod      r_xo_ab [4];
    t_prod      r_xo_cd [4];
    t_ocode     d1, d2, d3, d4;
    logic       hit;
    logic       r_crossed;

    // result register
    logic       r_out_valid;
    logic       r_wf, r_cr, r_cvx, r_ccv, r_av, r_ov;
    t_area      r_area;

    logic       in_acc;
    logic       out_load;
    logic       wf, cr, cvx, av;
    t_sum       abs_sum;
    t_area      area;
    t_cnt       jmax;

    assign in_acc      = i_vtx.valid && i_vtx.ready;
    assign i_vtx.ready = (r_state == S_IDLE);
    assign n_count     = (r_count < CNT_BITS'(MAX_VERTICES)) ? r_count + 1'b1 : r_count;
    assign jmax        = (r_i == '0) ? r_count - CNT_BITS'(2) : r_count - CNT_BITS'(1);

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        unique case (r_state)
            S_CV: begin
                addr_a = (r_s < r_count) ? r_s[ADDR_BITS-1:0]
                                         : ADDR_BITS'(r_s - r_count);
            end
            S_CR_OUT: begin
                addr_a = r_i[ADDR_BITS-1:0];
                addr_b = ADDR_BITS'(r_i + 1'b1);
            end
            S_CR_IN: begin
                addr_a = r_j[ADDR_BITS-1:0];
                addr_b = (r_j + 1'b1 == r_count) ? '0 : ADDR_BITS'(r_j + 1'b1);
            end
            default: begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    // vertex store
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CNT_BITS'(MAX_VERTICES)) begin
            mem[r_count[ADDR_BITS-1:0]] <= '{x: i_vtx.vertex_x, y: i_vtx.vertex_y};
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    // edge pair test outcome
    always_comb begin
        d1  = ocode(r_xo_ab[0], r_xo_cd[0]);
        d2  = ocode(r_xo_ab[1], r_xo_cd[1]);
        d3  = ocode(r_xo_ab[2], r_xo_cd[2]);
        d4  = ocode(r_xo_ab[3], r_xo_cd[3]);
        hit = (d1 != d2 && d3 != d4)
           || (d1 == OR_ZERO && in_box(r_x_p2, r_x_p1, r_x_q2))
           || (d2 == OR_ZERO && in_box(r_x_p2, r_x_q1, r_x_q2))
           || (d3 == OR_ZERO && in_box(r_x_p1, r_x_p2, r_x_q1))
           || (d4 == OR_ZERO && in_box(r_x_p1, r_x_q2, r_x_q1));
        cv_code = ocode(r_c_t1, r_c_t2);
    end

    // result fields
    always_comb begin
        wf      = (r_count >= CNT_BITS'(3));
        cr      = wf && r_crossed;
        cvx     = wf && !r_nonconvex;
        av      = wf && !cr;
        abs_sum = r_sum[SUM_BITS-1] ? -r_sum : r_sum;
        if (abs_sum[SUM_BITS-1:AREA_BITS] != '0) begin
            area = '1;
        end else begin
            area = abs_sum[AREA_BITS-1:0];
        end
        out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cv_v1     <= 1'b0;
            r_cv_v2     <= 1'b0;
            r_x_v1      <= 1'b0;
            r_x_v2      <= 1'b0;
        end else begin
            r_cv_v1 <= 1'b0;
            r_x_v1  <= 1'b0;
            r_cv_v2 <= r_cv_v1;
            r_x_v2  <= r_x_v1;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        if (r_count >= CNT_BITS'(MAX_VERTICES)) r_ovf <= 1'b1;
                        if (i_vtx.last_vertex) begin
                            r_s         <= '0;
                            r_sum       <= '0;
                            r_sign_set  <= 1'b0;
                            r_sign_neg  <= 1'b0;
                            r_nonconvex <= 1'b0;
                            r_crossed   <= 1'b0;
                            r_state     <= (n_count < CNT_BITS'(3)) ? S_DONE : S_CV;
                        end
                    end
                end
                S_CV: begin
                    r_cv_v1    <= 1'b1;
                    r_cv_pair1 <= (r_s != '0) && (r_s <= r_count);
                    r_cv_tri1  <= (r_s >= CNT_BITS'(2));
                    if (r_s == r_count + 1'b1) begin
                        if (r_count < CNT_BITS'(4)) begin
                            r_drn   <= 1'b1;
                            r_state <= S_DRAIN;
                        end else begin
                            r_i     <= '0;
                            r_state <= S_CR_OUT;
                        end
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_CR_OUT: begin
                    r_state <= S_CR_LAT;
                end
                S_CR_LAT: begin
                    r_p1    <= r_rd_a;
                    r_q1    <= r_rd_b;
                    r_j     <= r_i + CNT_BITS'(2);
                    r_state <= S_CR_IN;
                end
                S_CR_IN: begin
                    r_x_v1 <= 1'b1;
                    if (r_j == jmax) begin
                        if (r_i == r_count - CNT_BITS'(3)) begin
                            r_drn   <= 1'b1;
                            r_state <= S_DRAIN;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_CR_OUT;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_drn) r_state <= S_DONE;
                    r_drn <= 1'b0;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // accumulate turn signs and shoelace terms
            if (r_cv_v2) begin
                if (r_cv_pair2) r_sum <= r_sum + t_sum'(r_c_s1 - r_c_s2);
                if (r_cv_tri2 && cv_code != OR_ZERO) begin
                    if (!r_sign_set) begin
                        r_sign_set <= 1'b1;
                        r_sign_neg <= (cv_code == OR_NEG);
                    end else if (r_sign_neg != (cv_code == OR_NEG)) begin
                        r_nonconvex <= 1'b1;
                    end
                end
            end
            if (r_x_v2 && hit) r_crossed <= 1'b1;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_cv_v1) begin
            r_c_t1     <= dmul(r_wb.x, r_wa.x, r_rd_a.y, r_wb.y);
            r_c_t2     <= dmul(r_wb.y, r_wa.y, r_rd_a.x, r_wb.x);
            r_c_s1     <= t_prod'(r_rd_a.x) * t_prod'(r_wb.y);
            r_c_s2     <= t_prod'(r_rd_a.y) * t_prod'(r_wb.x);
            r_cv_pair2 <= r_cv_pair1;
            r_cv_tri2  <= r_cv_tri1;
            r_wa       <= r_wb;
            r_wb       <= r_rd_a;
        end
        if (r_x_v1) begin
            // orient(p, q, r) = (qy-py)(rx-qx) - (qx-px)(ry-qy)
            r_xo_ab[0] <= dmul(r_rd_b.y, r_rd_a.y, r_p1.x, r_rd_b.x);
            r_xo_cd[0] <= dmul(r_rd_b.x, r_rd_a.x, r_p1.y, r_rd_b.y);
            r_xo_ab[1] <= dmul(r_rd_b.y, r_rd_a.y, r_q1.x, r_rd_b.x);
            r_xo_cd[1] <= dmul(r_rd_b.x, r_rd_a.x, r_q1.y, r_rd_b.y);
            r_xo_ab[2] <= dmul(r_q1.y, r_p1.y, r_rd_a.x, r_q1.x);
            r_xo_cd[2] <= dmul(r_q1.x, r_p1.x, r_rd_a.y, r_q1.y);
            r_xo_ab[3] <= dmul(r_q1.y, r_p1.y, r_rd_b.x, r_q1.x);
            r_xo_cd[3] <= dmul(r_q1.x, r_p1.x, r_rd_b.y, r_q1.y);
            r_x_p1     <= r_p1;
            r_x_q1     <= r_q1;
            r_x_p2     <= r_rd_a;
            r_x_q2     <= r_rd_b;
        end
        if (out_load) begin
            r_wf   <= wf;
            r_cr   <= cr;
            r_cvx  <= cvx;
            r_ccv  <= av && !cvx;
            r_av   <= av;
            r_area <= av ? area : '0;
            r_ov   <= r_ovf;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.well_formed = r_wf;
    assign o_res.crossed     = r_cr;
    assign o_res.convex      = r_cvx;
    assign o_res.concave     = r_ccv;
    assign o_res.area_valid  = r_av;
    assign o_res.twice_area  = r_area;
    assign o_res.overflow    = r_ov;

    `PSA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(MAX_VERTICES))
    `PSA_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, in_acc && i_vtx.last_vertex, r_state != S_IDLE)
    `PSA_ASSERT_IMP(a_rose_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)
    `PSA_ASSERT_IMP(a_area_zero, i_clk, i_rst_n, r_out_valid && !r_av, r_area == '0)

endmodule

### verif/polygon_shape_analyzer_unit_tb.sv
// ----------------------------------------------------------------------------
// polygon_shape_analyzer_unit_tb
// feeds polygons one vertex per transaction with random gaps on both sides,
// predicts the shape flags and doubled area of each closed polygon and checks
// every result transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------
module polygon_shape_analyzer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psa_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
    } t_vtx_item;

    typedef struct {
        logic  well_formed;
        logic  crossed;
        logic  convex;
        logic  concave;
        logic  area_valid;
        t_area twice_area;
        logic  overflow;
    } t_shape;

    logic i_clk;
    logic i_rst_n;

    psa_in_if  vtx_if ();
    psa_out_if res_if ();

    polygon_shape_analyzer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_if.sink),
        .o_res   (res_if.source)
    );

    t_vtx_item pending_vtx[$];
    t_shape    expected_shapes[$];
    int        mismatch_count;
    int        idle_cycles;
    bit        stim_done;
    bit        hold_send;

    // shadow of the polygon store
    longint poly_x[MAX_VERTICES];
    longint poly_y[MAX_VERTICES];
    int     poly_n;
    bit     poly_ovf;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int turn_code(int p, int q, int r);
        longint v;
        v = (poly_y[q] - poly_y[p]) * (poly_x[r] - poly_x[q]) -
            (poly_x[q] - poly_x[p]) * (poly_y[r] - poly_y[q]);
        if (v == 0) return 0;
        return v > 0 ? 1 : 2;
    endfunction

    function automatic bit within_box(int p, int q, int r);
        return poly_x[q] <= ((poly_x[p] > poly_x[r]) ? poly_x[p] : poly_x[r]) &&
               poly_x[q] >= ((poly_x[p] < poly_x[r]) ? poly_x[p] : poly_x[r]) &&
               poly_y[q] <= ((poly_y[p] > poly_y[r]) ? poly_y[p] : poly_y[r]) &&
               poly_y[q] >= ((poly_y[p] < poly_y[r]) ? poly_y[p] : poly_y[r]);
    endfunction

    function automatic bit segments_touch(int i, int j, int n);
        int p1, q1, p2, q2, d1, d2, d3, d4;
        p1 = i; q1 = (i + 1) % n; p2 = j; q2 = (j + 1) % n;
        d1 = turn_code(p2, q2, p1);
        d2 = turn_code(p2, q2, q1);
        d3 = turn_code(p1, q1, p2);
        d4 = turn_code(p1, q1, q2);
        if (d1 != d2 && d3 != d4) return 1;
        if (d1 == 0 && within_box(p2, p1, q2)) return 1;
        if (d2 == 0 && within_box(p2, q1, q2)) return 1;
        if (d3 == 0 && within_box(p1, p2, q1)) return 1;
        if (d4 == 0 && within_box(p1, q2, q1)) return 1;
        return 0;
    endfunction

    function automatic t_shape close_polygon();
        t_shape s;
        int     n, sign, sg;
        longint cr, sum;
        n = poly_n;
        s = '{default: '0};
        s.overflow = poly_ovf;
        s.well_formed = n >= 3;
        if (s.well_formed) begin
            for (int i = 0; i < n && !s.crossed; i++)
                for (int j = i + 2; j < n; j++) begin
                    if (i == 0 && j == n - 1) continue;
                    if (segments_touch(i, j, n)) begin
                        s.crossed = 1;
                        break;
                    end
                end
            s.convex = 1;
            sign = 0;
            for (int i = 0; i < n; i++) begin
                int b, c;
                b = (i + 1) % n; c = (i + 2) % n;
                cr = (poly_x[b] - poly_x[i]) * (poly_y[c] - poly_y[b]) -
                     (poly_y[b] - poly_y[i]) * (poly_x[c] - poly_x[b]);
                if (cr != 0) begin
                    sg = cr > 0 ? 1 : -1;
                    if (sign == 0) sign = sg;
                    else if (sign != sg) s.convex = 0;
                end
            end
        end
        s.area_valid = s.well_formed && !s.crossed;
        s.concave = s.area_valid && !s.convex;
        if (s.area_valid) begin
            sum = 0;
            for (int k = 0; k < n; k++) begin
                int pv;
                pv = (k == 0) ? n - 1 : k - 1;
                sum += poly_x[k] * poly_y[pv] - poly_y[k] * poly_x[pv];
            end
            if (sum < 0) sum = -sum;
            if (sum > 64'h1_FFFF_FFFF) sum = 64'h1_FFFF_FFFF;
            s.twice_area = t_area'(sum);
        end
        poly_n = 0;
        poly_ovf = 0;
        return s;
    endfunction

    function automatic void absorb_vertex(t_vtx_item it);
        if (poly_n < MAX_VERTICES) begin
            poly_x[poly_n] = longint'(it.x);
            poly_y[poly_n] = longint'(it.y);
            poly_n++;
        end else begin
            poly_ovf = 1;
        end
        if (it.last) expected_shapes.push_back(close_polygon());
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // set at posedge unless the current transaction was offered and not yet taken
    bit vtx_accepted_hold;

    // driver
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            vtx_if.valid <= 1'b0;
            send_gap = 0;
        end else if (!(vtx_if.valid && !vtx_accepted_hold)) begin
            if (send_gap > 0 || hold_send || pending_vtx.size() == 0) begin
                if (send_gap > 0) send_gap--;
                vtx_if.valid <= 1'b0;
            end else begin
                t_vtx_item it;
                it = pending_vtx.pop_front();
                vtx_if.vertex_x    <= it.x;
                vtx_if.vertex_y    <= it.y;
                vtx_if.last_vertex <= it.last;
                vtx_if.valid       <= 1'b1;
                send_gap = gap_len();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vtx_accepted_hold <= 1'b0;
            idle_cycles <= 0;
        end else begin
            bit took;
            took = 0;
            if (vtx_if.valid && vtx_if.ready) begin
                t_vtx_item it;
                it.x = vtx_if.vertex_x;
                it.y = vtx_if.vertex_y;
                it.last = vtx_if.last_vertex;
                absorb_vertex(it);
                took = 1;
            end
            vtx_accepted_hold <= !(vtx_if.valid && !vtx_if.ready);
            if (res_if.valid && res_if.ready) begin
                took = 1;
                if (expected_shapes.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    t_shape e;
                    e = expected_shapes.pop_front();
                    if (res_if.well_formed !== e.well_formed)
                        report_mismatch("well_formed", res_if.well_formed, e.well_formed);
                    if (res_if.crossed !== e.crossed)
                        report_mismatch("crossed", res_if.crossed, e.crossed);
                    if (res_if.convex !== e.convex)
                        report_mismatch("convex", res_if.convex, e.convex);
                    if (res_if.concave !== e.concave)
                        report_mismatch("concave", res_if.concave, e.concave);
                    if (res_if.area_valid !== e.area_valid)
                        report_mismatch("area_valid", res_if.area_valid, e.area_valid);
                    if (res_if.twice_area !== e.twice_area)
                        report_mismatch("twice_area", res_if.twice_area, e.twice_area);
                    if (res_if.overflow !== e.overflow)
                        report_mismatch("overflow", res_if.overflow, e.overflow);
                end
            end
            idle_cycles <= took ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side back-pressure
    int stall_len;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_len = 0;
        end else if (stall_len > 0) begin
            stall_len--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            stall_len = gap_len();
        end
    end

    task automatic add_vtx(int x, int y, bit last);
        t_vtx_item it;
        it.x = t_coord'(x);
        it.y = t_coord'(y);
        it.last = last;
        pending_vtx.push_back(it);
    endtask

    // mostly small polygons, occasionally near or past the store size
    task automatic add_random_polygon();
        int n, r, span, cx, cy;
        r = $urandom_range(0, 99);
        if (r < 6) n = $urandom_range(1, 2);
        else if (r < 94) n = $urandom_range(3, 10);
        else n = $urandom_range(60, 70);
        r = $urandom_range(0, 3);
        span = (r == 0) ? 8 : (r == 1) ? 300 : (r == 2) ? 12000 : 32767;
        cx = (span == 32767) ? 0 : $urandom_range(0, 2 * (32767 - span)) - (32767 - span);
        cy = (span == 32767) ? 0 : $urandom_range(0, 2 * (32767 - span)) - (32767 - span);
        if ($urandom_range(0, 1)) begin
            // star-shaped: increasing angle around center, random radius
            for (int k = 0; k < n; k++) begin
                real a, rad;
                a = 6.2831853 * (k + $urandom_range(0, 99) / 120.0) / n;
                rad = span * ($urandom_range(30, 100) / 100.0);
                add_vtx(cx + $rtoi(rad * $cos(a)), cy + $rtoi(rad * $sin(a)), k == n - 1);
            end
        end else begin
            for (int k = 0; k < n; k++)
                add_vtx(cx + $urandom_range(0, 2 * span) - span,
                        cy + $urandom_range(0, 2 * span) - span, k == n - 1);
        end
    endtask

    initial begin
        int sent;
        bit paused;
        mismatch_count = 0;
        stim_done = 0;
        hold_send = 0;
        paused = 0;
        poly_n = 0;
        poly_ovf = 0;
        i_rst_n = 1'b0;
        vtx_if.valid = 1'b0;
        vtx_if.vertex_x = '0;
        vtx_if.vertex_y = '0;
        vtx_if.last_vertex = 1'b0;
        res_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: lone vertex, two, triangle at extremes, square, bow tie,
        // collinear, concave, duplicate vertex, overflow
        add_vtx(-32768, 32767, 1);
        add_vtx(1, 2, 0); add_vtx(3, 4, 1);
        add_vtx(-32768, -32768, 0); add_vtx(32767, -32768, 0); add_vtx(32767, 32767, 1);
        add_vtx(-32768, -32768, 0); add_vtx(32767, -32768, 0);
        add_vtx(32767, 32767, 0); add_vtx(-32768, 32767, 1);
        add_vtx(0, 0, 0); add_vtx(10, 10, 0); add_vtx(10, 0, 0); add_vtx(0, 10, 1);
        add_vtx(0, 0, 0); add_vtx(5, 5, 0); add_vtx(10, 10, 1);
        add_vtx(0, 0, 0); add_vtx(10, 0, 0); add_vtx(2, 2, 0); add_vtx(0, 10, 1);
        add_vtx(0, 0, 0); add_vtx(0, 0, 0); add_vtx(4, 0, 0); add_vtx(0, 4, 1);
        for (int k = 0; k < MAX_VERTICES + 3; k++)
            add_vtx(k * 97 - 3000, (k * k) % 211 - 100, k == MAX_VERTICES + 2);

        sent = pending_vtx.size();
        while (sent < 1550) begin
            int before_sz;
            before_sz = pending_vtx.size();
            add_random_polygon();
            sent += pending_vtx.size() - before_sz;
            // sender holds off until the block has drained
            if (sent > 700 && !paused) begin
                paused = 1;
                wait (pending_vtx.size() == 0 && !vtx_if.valid);
                hold_send = 1;
                wait (expected_shapes.size() == 0);
                hold_send = 0;
            end
            while (pending_vtx.size() > 40) @(posedge i_clk);
        end
        wait (pending_vtx.size() == 0 && !vtx_if.valid);
        stim_done = 1;
        wait (expected_shapes.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
